[rtl/core/rbat_pkg.sv]
package rbat_pkg;

	// field widths
	localparam int COORD_W   = 6;
	localparam int ALPHA_W   = 8;
	localparam int OFS_W     = 26;
	localparam int TS_W      = 16;
	localparam int RAD_W     = 24;
	localparam int STR_W     = 16;
	localparam int FO_W      = 16;
	localparam int CFG_W     = 26;
	localparam int CFG_IDX_W = 3;

	// fixed point
	localparam int D_W       = 32;            // signed axis offset, Q.13
	localparam int AD_W      = D_W - 1;       // its magnitude
	localparam int SQ_W      = 2 * AD_W;      // one squared axis
	localparam int D2_W      = SQ_W + 1;      // squared distance
	localparam int R_W       = RAD_W + 5;     // radius in Q.13
	localparam int R2_W      = 2 * R_W;       // squared radius
	localparam int Q_W       = 15;            // Q.15 quotients
	localparam int INFL_W    = 16;
	localparam int ONE_Q15   = 32768;
	localparam int MIN_FALLOFF_Q15 = 32;
	localparam int ACC_SHIFT = 29;
	localparam int DELTA_W   = STR_W + INFL_W + 8;
	localparam int ACC_W     = DELTA_W + 1;

	// defaults
	localparam int MAP_SIDE_DEF    = 64;
	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int FRONT_STAGES    = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET_X   = 3'd0,
		REG_OFFSET_Y   = 3'd1,
		REG_TEXEL_SIZE = 3'd2,
		REG_RADIUS     = 3'd3,
		REG_STRENGTH   = 3'd4,
		REG_FALLOFF    = 3'd5,
		REG_ERASE_MODE = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0] texel_col;
		logic [COORD_W-1:0] texel_row;
		logic [ALPHA_W-1:0] alpha_in;
	} item_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha_out;
		logic               inside_brush;
	} result_t;

	typedef struct packed {
		logic signed [OFS_W-1:0] offset_x;
		logic signed [OFS_W-1:0] offset_y;
		logic [TS_W-1:0]         texel_size;
		logic [RAD_W-1:0]        radius;
		logic [STR_W-1:0]        strength;
		logic [FO_W-1:0]         falloff;
		logic                    erase_mode;
	} cfg_t;

	// classified texel handed from front to back
	typedef struct packed {
		logic               in_brush;
		logic [ALPHA_W-1:0] alpha;
		logic [R2_W-1:0]    d2;
	} qent_t;

	typedef struct packed {
		logic nearly_full;
		logic empty;
	} qstat_t;

endpackage

[rtl/core/rbat_front.sv]
module rbat_front import rbat_pkg::*; #(
	parameter int MAP_SIDE = MAP_SIDE_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  take,
	input  item_t item,
	input  cfg_t  cfg,
	output logic  push,
	output qent_t push_data
);

	localparam int IDX_W = $clog2(MAP_SIDE);
	localparam int PR_W  = IDX_W + 1 + TS_W;

	// index wrap by repeated subtraction, at most eight steps
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [COORD_W-1:0] v);
		logic [8:0] w;
		w = 9'(v);
		for (int i = 0; i < 8; i++) begin
			if (w >= 9'(MAP_SIDE)) begin
				w = w - 9'(MAP_SIDE);
			end
		end
		return w[IDX_W-1:0];
	endfunction

	logic             v_s1, v_s2, v_s3;
	logic [IDX_W-1:0] col_s1, row_s1;
	logic [ALPHA_W-1:0] alpha_s1, alpha_s2, alpha_s3;
	logic [AD_W-1:0]  adx_s2, ady_s2;
	logic [SQ_W-1:0]  sqx_s3, sqy_s3;
	logic [R2_W-1:0]  r2_q;
	logic             r_nz_q;

	logic signed [D_W-1:0] dx, dy;
	logic [PR_W-1:0]  px, py;
	logic [D2_W-1:0]  d2;

	// axis offsets of the texel centre
	always_comb begin
		px = PR_W'({row_s1, 1'b1}) * PR_W'(cfg.texel_size);
		py = PR_W'({col_s1, 1'b1}) * PR_W'(cfg.texel_size);
		dx = D_W'($signed({cfg.offset_x, 5'b0})) - $signed(D_W'(px));
		dy = D_W'($signed({cfg.offset_y, 5'b0})) - $signed(D_W'(py));
		d2 = D2_W'(sqx_s3) + D2_W'(sqy_s3);
	end

	// squared radius, refreshed every cycle
	always_ff @(posedge clk) begin
		r2_q   <= R2_W'(R_W'({cfg.radius, 5'b0}) * R_W'({cfg.radius, 5'b0}));
		r_nz_q <= (cfg.radius != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		col_s1   <= wrap_idx(item.texel_col);
		row_s1   <= wrap_idx(item.texel_row);
		alpha_s1 <= item.alpha_in;
		adx_s2   <= dx[D_W-1] ? AD_W'(-dx) : AD_W'(dx);
		ady_s2   <= dy[D_W-1] ? AD_W'(-dy) : AD_W'(dy);
		alpha_s2 <= alpha_s1;
		sqx_s3   <= adx_s2 * adx_s2;
		sqy_s3   <= ady_s2 * ady_s2;
		alpha_s3 <= alpha_s2;
	end

	// classify against the radius
	assign push               = v_s3;
	assign push_data.in_brush = r_nz_q && (d2 < D2_W'(r2_q));
	assign push_data.alpha    = alpha_s3;
	assign push_data.d2       = d2[R2_W-1:0];

endmodule

[rtl/core/rbat_queue.sv]
module rbat_queue import rbat_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qent_t  push_data,
	output logic   out_valid,
	output qent_t  out_data,
	output qstat_t stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	qent_t            mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	// the back end never stalls, so drain whenever something is held
	assign pop              = (cnt_q != '0);
	assign stat.empty       = (cnt_q == '0);
	assign stat.nearly_full = (cnt_q >= CNT_W'(DEPTH - FRONT_STAGES));

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
		out_data <= mem[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q      <= '0;
			rd_q      <= '0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			out_valid <= pop;
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

[rtl/core/rbat_div.sv]
module rbat_div import rbat_pkg::*; #(
	parameter int DEN_W = 16,
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [DEN_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag_in,
	output logic             out_valid,
	output logic [Q_W-1:0]   quo,
	output logic [TAG_W-1:0] tag_out
);

	// restoring division of num*2^Q_W by den, num below den, one bit a stage
	logic [DEN_W-1:0] rem_s [Q_W];
	logic [Q_W-1:0]   quo_s [Q_W];
	logic [TAG_W-1:0] tag_s [Q_W];
	logic             vld_s [Q_W];

	for (genvar g = 0; g < Q_W; g++) begin : g_stage
		logic [DEN_W-1:0] r_in;
		logic [Q_W-1:0]   q_in;
		logic [TAG_W-1:0] t_in;
		logic             v_in;
		logic [DEN_W:0]   shl;
		logic             ge;

		if (g == 0) begin : g_first
			assign r_in = num;
			assign q_in = '0;
			assign t_in = tag_in;
			assign v_in = in_valid;
		end else begin : g_next
			assign r_in = rem_s[g-1];
			assign q_in = quo_s[g-1];
			assign t_in = tag_s[g-1];
			assign v_in = vld_s[g-1];
		end

		assign shl = {r_in, 1'b0};
		assign ge  = (shl >= {1'b0, den});

		always_ff @(posedge clk) begin
			rem_s[g] <= ge ? DEN_W'(shl - {1'b0, den}) : DEN_W'(shl);
			quo_s[g] <= {q_in[Q_W-2:0], ge};
			tag_s[g] <= t_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= v_in;
			end
		end
	end

	assign out_valid = vld_s[Q_W-1];
	assign quo       = quo_s[Q_W-1];
	assign tag_out   = tag_s[Q_W-1];

endmodule

[rtl/core/rbat_back.sv]
module rbat_back import rbat_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  qent_t   in_data,
	input  cfg_t    cfg,
	output logic    done,
	output result_t result
);

	localparam int SB_W = ALPHA_W + 1;

	// integer square root, one root bit a stage
	logic [R2_W-1:0] srem_s [R_W];
	logic [R_W-1:0]  sroot_s [R_W];
	logic [SB_W-1:0] ssb_s [R_W];
	logic            svld_s [R_W];

	for (genvar g = 0; g < R_W; g++) begin : g_sqrt
		localparam int B = R_W - 1 - g;
		logic [R2_W-1:0] r_in;
		logic [R_W-1:0]  q_in;
		logic [SB_W-1:0] sb_in;
		logic            v_in;
		logic [R2_W:0]   trial;
		logic            ge;

		if (g == 0) begin : g_first
			assign r_in  = in_data.d2;
			assign q_in  = '0;
			assign sb_in = {in_data.in_brush, in_data.alpha};
			assign v_in  = in_valid;
		end else begin : g_next
			assign r_in  = srem_s[g-1];
			assign q_in  = sroot_s[g-1];
			assign sb_in = ssb_s[g-1];
			assign v_in  = svld_s[g-1];
		end

		assign trial = ((R2_W + 1)'(q_in) << (B + 1)) | ((R2_W + 1)'(1) << (2 * B));
		assign ge    = ((R2_W + 1)'(r_in) >= trial);

		always_ff @(posedge clk) begin
			srem_s[g]  <= ge ? R2_W'((R2_W + 1)'(r_in) - trial) : r_in;
			sroot_s[g] <= ge ? (q_in | (R_W'(1) << B)) : q_in;
			ssb_s[g]   <= sb_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				svld_s[g] <= 1'b0;
			end else begin
				svld_s[g] <= v_in;
			end
		end
	end

	// radial position t = dist / radius in Q.15
	logic             t_vld;
	logic [Q_W-1:0]   t_val;
	logic [SB_W-1:0]  t_sb;

	rbat_div #(.DEN_W(R_W), .TAG_W(SB_W)) u_div_t (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (svld_s[R_W-1]),
		.num      (sroot_s[R_W-1]),
		.den      (R_W'({cfg.radius, 5'b0})),
		.tag_in   (ssb_s[R_W-1]),
		.out_valid(t_vld),
		.quo      (t_val),
		.tag_out  (t_sb)
	);

	// soft band test
	logic [FO_W-1:0]   fo, inner;
	logic              band;
	logic              bvld_s1, band_s1;
	logic [FO_W-1:0]   diff_s1;
	logic [SB_W-1:0]   bsb_s1;

	always_comb begin
		fo    = (cfg.falloff > FO_W'(ONE_Q15)) ? FO_W'(ONE_Q15) : cfg.falloff;
		inner = FO_W'(ONE_Q15) - fo;
		band  = (fo > FO_W'(MIN_FALLOFF_Q15)) && (FO_W'(t_val) > inner);
	end

	always_ff @(posedge clk) begin
		band_s1 <= band;
		diff_s1 <= band ? FO_W'(t_val) - inner : '0;
		bsb_s1  <= t_sb;
	end

	// position within the band, ft in Q.15
	logic             f_vld;
	logic [Q_W-1:0]   ft;
	logic [SB_W:0]    f_sb;

	rbat_div #(.DEN_W(FO_W), .TAG_W(SB_W + 1)) u_div_ft (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bvld_s1),
		.num      (diff_s1),
		.den      (fo),
		.tag_in   ({band_s1, bsb_s1}),
		.out_valid(f_vld),
		.quo      (ft),
		.tag_out  (f_sb)
	);

	// influence, then strength scaling
	logic [2*Q_W-1:0]   ftsq;
	logic               vld_s2, vld_s3, vld_s4;
	logic [INFL_W-1:0]  infl_s2;
	logic [STR_W+INFL_W-1:0] p_s3;
	logic [DELTA_W-1:0] delta_s4;
	logic [SB_W-1:0]    sb_s2, sb_s3, sb_s4;

	assign ftsq = ft * ft;

	always_ff @(posedge clk) begin
		infl_s2  <= f_sb[SB_W] ? INFL_W'(ONE_Q15) - INFL_W'(ftsq[2*Q_W-1:Q_W])
		                       : INFL_W'(ONE_Q15);
		sb_s2    <= f_sb[SB_W-1:0];
		p_s3     <= cfg.strength * infl_s2;
		sb_s3    <= sb_s2;
		delta_s4 <= (DELTA_W'(p_s3) << 8) - DELTA_W'(p_s3);
		sb_s4    <= sb_s3;
	end

	// accumulate and clamp
	logic [ACC_W-1:0]   base, sum;
	logic [ALPHA_W-1:0] blended;
	localparam logic [ACC_W-1:0] FULL = ACC_W'(255) << ACC_SHIFT;

	always_comb begin
		base = ACC_W'(sb_s4[ALPHA_W-1:0]) << ACC_SHIFT;
		if (cfg.erase_mode) begin
			sum     = base - ACC_W'(delta_s4);
			blended = (ACC_W'(delta_s4) > base) ? '0 : sum[ACC_SHIFT +: ALPHA_W];
		end else begin
			sum     = base + ACC_W'(delta_s4);
			blended = (sum >= FULL) ? ALPHA_W'(255) : sum[ACC_SHIFT +: ALPHA_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvld_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			done    <= 1'b0;
			result  <= '0;
		end else begin
			bvld_s1 <= t_vld;
			vld_s2  <= f_vld;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			done    <= vld_s4;
			result.alpha_out    <= sb_s4[ALPHA_W] ? blended : sb_s4[ALPHA_W-1:0];
			result.inside_brush <= vld_s4 && sb_s4[ALPHA_W];
		end
	end

endmodule

[rtl/core/radial_brush_alpha_texel.sv]
// radial brush stamp, one alpha texel per beat
// input: raise start with item (column, row, current alpha); the beat is taken
// at a rising edge where start is high and busy is low. busy stays low in
// normal streaming, so one texel can be taken every cycle.
// output: done is high for one cycle with result (new alpha, inside flag);
// the receiver must take it then, there is no back-pressure.
// the path from the accepting edge to done runs through 3 front stages (index
// wrap, offsets, squares; the radius compare is combinational), the queue
// (write, registered read), 29 square-root stages, two 15-stage dividers
// (radial position, band position), the band test and 4 stages for influence,
// strength product, delta and the clamped output.
// throughput is one texel per cycle; results leave in input order.
// configuration: wr_en, wr_index, wr_data write one register per edge;
// write only while no texel is in flight. index 7 is ignored.
// reset clears the configuration, valid flags and result to zero and empties the pipeline and queue.
module radial_brush_alpha_texel import rbat_pkg::*; #(
	parameter int MAP_SIDE    = MAP_SIDE_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  item_t                item,
	output logic                 done,
	output result_t              result,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data
);

	cfg_t   cfg_q;
	logic   push;
	qent_t  push_data;
	logic   q_valid;
	qent_t  q_data;
	qstat_t q_stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_OFFSET_X:   cfg_q.offset_x   <= wr_data[OFS_W-1:0];
				REG_OFFSET_Y:   cfg_q.offset_y   <= wr_data[OFS_W-1:0];
				REG_TEXEL_SIZE: cfg_q.texel_size <= wr_data[TS_W-1:0];
				REG_RADIUS:     cfg_q.radius     <= wr_data[RAD_W-1:0];
				REG_STRENGTH:   cfg_q.strength   <= wr_data[STR_W-1:0];
				REG_FALLOFF:    cfg_q.falloff    <= wr_data[FO_W-1:0];
				REG_ERASE_MODE: cfg_q.erase_mode <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign busy = q_stat.nearly_full;

	rbat_front #(.MAP_SIDE(MAP_SIDE)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (start && !busy),
		.item     (item),
		.cfg      (cfg_q),
		.push     (push),
		.push_data(push_data)
	);

	rbat_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.out_valid(q_valid),
		.out_data (q_data),
		.stat     (q_stat)
	);

	rbat_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(q_valid),
		.in_data (q_data),
		.cfg     (cfg_q),
		.done    (done),
		.result  (result)
	);

endmodule

[rtl/core/rbat_checker.sv]
module rbat_checker import rbat_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// the queue drains every cycle, so it never backs up to the front
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised while the queue drains every cycle");

	// nothing leaves in the first cycle after reset
	a_quiet_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !done)
		else $error("result beat straight after reset");

	// the inside flag is only shown with a result beat
	a_inside_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.inside_brush |-> done)
		else $error("inside flag without a result beat");

endmodule

bind radial_brush_alpha_texel rbat_checker u_rbat_checker (.*);
